// ===== rtl/core/multiplexed_seven_segment_scanner_assert.svh =====
// assertion macros for the rtl file that checks itself
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCANNER_ASSERT_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must hold at every clock edge outside reset
`define MSSS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define MSSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in a cycle implies consequent in the next cycle
`define MSSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define MSSS_ASSERT_ALWAYS(lbl, cond, msg)
`define MSSS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MSSS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/msss_pkg.sv =====
package msss_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int DIG_W      = $clog2(MAX_DIGITS);
  localparam int NUM_W      = 4;
  localparam int POS_W      = 3;
  localparam int BCD_W      = 4;
  localparam int SEG_W      = 8;
  localparam int PER_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam logic [SEG_W-1:0]  POINT_MASK    = SEG_W'(1 << 7);
  localparam logic [NUM_W-1:0]  NUM_DIGITS_RST = NUM_W'(8);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_DIGITS   = 2'd0,
    CFG_BLINK_FROM   = 2'd1,
    CFG_BLINK_TO     = 2'd2,
    CFG_BLINK_PERIOD = 2'd3
  } cfg_idx_t;

  // bcd to segments a-g, blank above nine
  function automatic logic [SEG_W-1:0] seg_decode(input logic [BCD_W-1:0] bcd);
    logic [SEG_W-1:0] seg;
    case (bcd)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== rtl/core/msss_ram.sv =====
module msss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/multiplexed_seven_segment_scanner.sv =====
// channel | ports                              | payload
// --------+------------------------------------+---------------------------------------
// in      | in_tvalid in_tready in_tdata[15:0]  | cmd, position, bcd_value, start_new
// out     | out_tvalid out_tready out_tdata[15:0] | segments, digit_select
// cfg     | cfg_we cfg_index[1:0] cfg_wdata[15:0] | num_digits, blink_from/to, period
//
// one request per cycle sustained unless a tick is stalled on the out side; a
// refresh tick is read from the pattern ram at the accept edge and its result
// is loaded into the output register when the read stage moves on
// the rate is set by the registered read of the pattern ram plus write-back
// in the next stage, with forwarding of that write-back to the following read
// rst_n is synchronous; after reset the store reads blank through valid bits
// a stalled out side holds one result in the output register and one tick in
// the read stage; only then does in_tready drop
module multiplexed_seven_segment_scanner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [1:0] cmd, [4:2] position, [8:5] bcd_value, [9] start_new, rest zero
  input  logic [msss_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] segments, [10:8] digit_select, rest zero
  output logic [msss_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                          cfg_we,
  input  logic [msss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import msss_pkg::*;

  `include "multiplexed_seven_segment_scanner_assert.svh"

  // configuration registers
  logic [NUM_W-1:0] num_digits_r;
  logic [POS_W-1:0] blink_from_r;
  logic [POS_W-1:0] blink_to_r;
  logic [PER_W-1:0] blink_period_r;

  // scan state
  logic [DIG_W-1:0] active_r, active_nxt;
  logic [PER_W-1:0] blink_cnt_r, blink_cnt_nxt;

  // valid bit per stored pattern, clear means blank
  logic [MAX_DIGITS-1:0] valid_r, valid_nxt;

  // read stage
  logic             s1_vld_r, s1_vld_nxt;
  cmd_t             s1_cmd_r;
  logic [DIG_W-1:0] s1_addr_r;
  logic [BCD_W-1:0] s1_bcd_r;
  logic             s1_wen_r;
  logic             s1_fresh_r;
  logic             s1_blank_r;

  // last write-back, for a read issued in the same cycle
  logic             fwd_vld_r;
  logic [DIG_W-1:0] fwd_addr_r;
  logic [SEG_W-1:0] fwd_data_r;

  // output register
  logic             out_vld_r, out_vld_nxt;
  logic [SEG_W-1:0] out_seg_r;
  logic [DIG_W-1:0] out_dig_r;

  logic             in_accept;
  cmd_t             in_cmd;
  logic [POS_W-1:0] in_pos;
  logic [BCD_W-1:0] in_bcd;
  logic             in_fresh;

  logic [NUM_W-1:0] n_eff;
  logic [NUM_W-1:0] active_inc;
  logic [DIG_W-1:0] tick_digit;
  logic             pos_in_range;
  logic [DIG_W-1:0] rd_addr;
  logic [PER_W:0]   cnt_inc;
  logic [PER_W-1:0] cnt_wrap;
  logic [PER_W-1:0] cnt_new;
  logic             blank_new;

  logic [SEG_W-1:0] ram_rdata;
  logic [SEG_W-1:0] mem_word;
  logic [SEG_W-1:0] wr_data;
  logic             s1_done;
  logic             s1_wr;
  logic             s1_tick_go;

  // unpack the request
  assign in_cmd   = cmd_t'(in_tdata[1:0]);
  assign in_pos   = in_tdata[4:2];
  assign in_bcd   = in_tdata[8:5];
  assign in_fresh = in_tdata[9];

  assign in_accept = in_tvalid && in_tready;

  // digit count clamped to 1..MAX_DIGITS
  always_comb begin
    if (num_digits_r == '0) begin
      n_eff = NUM_W'(1);
    end else if (num_digits_r > NUM_W'(MAX_DIGITS)) begin
      n_eff = NUM_W'(MAX_DIGITS);
    end else begin
      n_eff = num_digits_r;
    end
  end

  // next scan position, wrapping at the digit count
  assign active_inc   = {{(NUM_W-DIG_W){1'b0}}, active_r} + NUM_W'(1);
  assign tick_digit   = (active_inc >= n_eff) ? '0 : active_inc[DIG_W-1:0];
  assign pos_in_range = {{(NUM_W-POS_W){1'b0}}, in_pos} < n_eff;
  assign rd_addr      = (in_cmd == CMD_TICK) ? tick_digit : in_pos[DIG_W-1:0];

  // blink counter steps modulo the period on each wrap to digit zero;
  // it never reaches the period, so the wrap is a single compare
  assign cnt_inc  = {1'b0, blink_cnt_r} + (PER_W+1)'(1);
  assign cnt_wrap = (cnt_inc == {1'b0, blink_period_r}) ? '0 : cnt_inc[PER_W-1:0];

  always_comb begin
    cnt_new = blink_cnt_r;
    if (blink_period_r != '0 && tick_digit == '0) begin
      cnt_new = cnt_wrap;
    end
  end

  // blank digits inside the range while the phase is above half the period
  assign blank_new = (blink_period_r != '0)
                  && ({{(POS_W-DIG_W){1'b0}}, tick_digit} >= blink_from_r)
                  && ({{(POS_W-DIG_W){1'b0}}, tick_digit} <= blink_to_r)
                  && (cnt_new > (blink_period_r >> 1));

  always_comb begin
    active_nxt    = active_r;
    blink_cnt_nxt = blink_cnt_r;
    if (in_accept && in_cmd == CMD_TICK) begin
      active_nxt    = tick_digit;
      blink_cnt_nxt = cnt_new;
    end
    if (cfg_we && (cfg_index == CFG_BLINK_FROM || cfg_index == CFG_BLINK_TO ||
                   cfg_index == CFG_BLINK_PERIOD)) begin
      blink_cnt_nxt = '0;
    end
  end

  // pattern store
  msss_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_addr_r),
    .wdata (wr_data),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // read data with forwarding of the write-back made at the read edge
  always_comb begin
    if (fwd_vld_r && fwd_addr_r == s1_addr_r) begin
      mem_word = fwd_data_r;
    end else if (valid_r[s1_addr_r]) begin
      mem_word = ram_rdata;
    end else begin
      mem_word = '0;
    end
  end

  assign wr_data = (s1_cmd_r == CMD_WRITE) ? seg_decode(s1_bcd_r) : (mem_word ^ POINT_MASK);

  // only a tick waits, and only for the output register
  assign s1_done    = !s1_vld_r || s1_cmd_r != CMD_TICK || !out_vld_r || out_tready;
  assign s1_wr      = s1_vld_r && s1_wen_r && s1_done;
  assign s1_tick_go = s1_vld_r && s1_cmd_r == CMD_TICK && s1_done;
  assign in_tready  = s1_done;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (s1_done) begin
      s1_vld_nxt = in_accept;
    end
  end

  // a fresh write clears the store, then sets its own entry if it is in range
  always_comb begin
    valid_nxt = valid_r;
    if (s1_vld_r && s1_cmd_r == CMD_WRITE && s1_fresh_r) begin
      valid_nxt = '0;
    end
    if (s1_wr) begin
      valid_nxt[s1_addr_r] = 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_tick_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_digits_r   <= NUM_DIGITS_RST;
      blink_from_r   <= '0;
      blink_to_r     <= '0;
      blink_period_r <= '0;
      active_r       <= DIG_W'(MAX_DIGITS - 1);
      blink_cnt_r    <= '0;
      valid_r        <= '0;
      s1_vld_r       <= 1'b0;
      fwd_vld_r      <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_NUM_DIGITS:   num_digits_r   <= cfg_wdata[NUM_W-1:0];
          CFG_BLINK_FROM:   blink_from_r   <= cfg_wdata[POS_W-1:0];
          CFG_BLINK_TO:     blink_to_r     <= cfg_wdata[POS_W-1:0];
          CFG_BLINK_PERIOD: blink_period_r <= cfg_wdata[PER_W-1:0];
          default: ;
        endcase
      end
      active_r    <= active_nxt;
      blink_cnt_r <= blink_cnt_nxt;
      valid_r     <= valid_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      if (in_accept) begin
        fwd_vld_r <= s1_wr;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r   <= in_cmd;
      s1_addr_r  <= rd_addr;
      s1_bcd_r   <= in_bcd;
      s1_fresh_r <= in_fresh;
      s1_wen_r   <= (in_cmd == CMD_WRITE || in_cmd == CMD_TOGGLE) && pos_in_range;
      s1_blank_r <= blank_new;
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= wr_data;
    end
    if (s1_tick_go) begin
      out_seg_r <= s1_blank_r ? '0 : mem_word;
      out_dig_r <= s1_addr_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-SEG_W-DIG_W){1'b0}}, out_dig_r, out_seg_r};

  `MSSS_ASSERT_ALWAYS(a_cnt_below_period,
    blink_period_r == '0 || blink_cnt_r < blink_period_r,
    "blink counter reached the period")
  `MSSS_ASSERT_IMPLY(a_tick_stall_blocks_in,
    s1_vld_r && s1_cmd_r == CMD_TICK && out_vld_r && !out_tready, !in_tready,
    "request taken while a tick is stalled")
  `MSSS_ASSERT_NEXT(a_accept_fills_stage,
    in_accept, s1_vld_r,
    "accepted request missing from read stage")
  `MSSS_ASSERT_NEXT(a_tick_loads_output,
    s1_tick_go, out_vld_r && out_dig_r == $past(s1_addr_r),
    "tick result not loaded into output register")

endmodule

// ===== test/tb_multiplexed_seven_segment_scanner.sv =====
module tb_multiplexed_seven_segment_scanner;
  import msss_pkg::*;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [1:0] cmd, [4:2] position, [8:5] bcd_value, [9] start_new, rest zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [7:0] segments, [10:8] digit_select, rest zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
  localparam int DRAIN_WAIT  = 4;     // lets pending writes settle after the last scan result

  always #6 clk = ~clk;

  multiplexed_seven_segment_scanner u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // scan predictor: its own copy of registers and display state
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [2:0]       digit_select;
  } scan_result_t;

  // segments a-g for decimal digits 0..9, point bit clear
  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic [3:0]  digits_reg;
  logic [2:0]  blink_lo_reg;
  logic [2:0]  blink_hi_reg;
  logic [15:0] blink_len_reg;
  logic [7:0]  glyph_store [MAX_DIGITS];
  int          scan_pos;
  logic [15:0] blink_phase;

  scan_result_t scan_expected [$];

  int mismatches    = 0;
  int requests_sent = 0;
  int scans_seen    = 0;
  int settings_used = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // out-of-range digit counts are clamped to 1..MAX_DIGITS
  function automatic int shown_digits();
    if (digits_reg == 0) return 1;
    if (digits_reg > MAX_DIGITS) return MAX_DIGITS;
    return int'(digits_reg);
  endfunction

  function automatic void predict_request(cmd_t cmd, logic [2:0] pos, logic [3:0] bcd,
                                          logic fresh);
    int           n;
    scan_result_t res;
    n = shown_digits();
    case (cmd)
      CMD_WRITE: begin
        if (fresh) foreach (glyph_store[i]) glyph_store[i] = '0;
        // a new digit replaces the whole pattern, point included
        if (pos < n) glyph_store[pos] = (bcd <= 9) ? DIGIT_GLYPH[bcd] : 8'h00;
      end
      CMD_TOGGLE: begin
        if (pos < n) glyph_store[pos] = glyph_store[pos] ^ POINT_MASK;
      end
      CMD_TICK: begin
        // wrap also when the count shrank below the current digit
        if (scan_pos + 1 >= n) scan_pos = 0;
        else scan_pos = scan_pos + 1;
        res.segments     = glyph_store[scan_pos];
        res.digit_select = 3'(scan_pos);
        if (blink_len_reg != 0) begin
          if (scan_pos == 0) blink_phase = 16'((32'(blink_phase) + 1) % 32'(blink_len_reg));
          if (scan_pos >= blink_lo_reg && scan_pos <= blink_hi_reg &&
              blink_phase > (blink_len_reg >> 1))
            res.segments = '0;
        end
        scan_expected.push_back(res);
      end
      default: ;  // unused command leaves everything alone
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 30)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall, then compare each scan result in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_scan
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      scans_seen++;
      if (scan_expected.size() == 0) begin
        report_mismatch("unexpected scan result", int'(out_tdata), 0);
      end else begin
        want = scan_expected.pop_front();
        if (out_tdata[7:0] !== want.segments)
          report_mismatch("segments", int'(out_tdata[7:0]), int'(want.segments));
        if (out_tdata[10:8] !== want.digit_select)
          report_mismatch("digit_select", int'(out_tdata[10:8]), int'(want.digit_select));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no handshake happens for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, scan_expected.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(cmd_t cmd, logic [2:0] pos, logic [3:0] bcd, logic fresh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, fresh, bcd, pos, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(cmd, pos, bcd, fresh);
    requests_sent++;
  endtask

  // drop valid, let every pending scan come out, then let writes settle
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (scan_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // one register write; leaves cfg_we high for the caller to lower
  task automatic cfg_write(cfg_idx_t idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_NUM_DIGITS:   digits_reg = data[3:0];
      CFG_BLINK_FROM:   begin blink_lo_reg  = data[2:0]; blink_phase = '0; end
      CFG_BLINK_TO:     begin blink_hi_reg  = data[2:0]; blink_phase = '0; end
      CFG_BLINK_PERIOD: begin blink_len_reg = data;      blink_phase = '0; end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // write the registers picked by sel (bit per register index) while idle
  task automatic apply_setting(logic [3:0] nd, logic [2:0] lo, logic [2:0] hi,
                               logic [15:0] len, logic [3:0] sel);
    wait_quiet();
    if (sel[CFG_NUM_DIGITS])   cfg_write(CFG_NUM_DIGITS, 16'(nd));
    if (sel[CFG_BLINK_FROM])   cfg_write(CFG_BLINK_FROM, 16'(lo));
    if (sel[CFG_BLINK_TO])     cfg_write(CFG_BLINK_TO, 16'(hi));
    if (sel[CFG_BLINK_PERIOD]) cfg_write(CFG_BLINK_PERIOD, len);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic set_pacing(int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endtask

  // mostly ticks and writes to visible digits, some noise beyond the count
  task automatic random_request();
    int         pick;
    int         n;
    logic [2:0] pos;
    logic [3:0] bcd;
    n    = shown_digits();
    pick = $urandom_range(99);
    pos  = ($urandom_range(99) < 85) ? 3'($urandom_range(n - 1)) : 3'($urandom_range(7));
    bcd  = ($urandom_range(99) < 80) ? 4'($urandom_range(9)) : 4'($urandom_range(15));
    if (pick < 45)      send_request(CMD_TICK, 3'($urandom_range(7)), 4'($urandom_range(15)),
                                     1'($urandom_range(1)));
    else if (pick < 75) send_request(CMD_WRITE, pos, bcd, ($urandom_range(9) == 0));
    else if (pick < 93) send_request(CMD_TOGGLE, pos, 4'($urandom_range(15)),
                                     1'($urandom_range(1)));
    else                send_request(CMD_NOP, 3'($urandom_range(7)), 4'($urandom_range(15)),
                                     1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // decode of every kind of value, points, overwrite and the unused command
  task automatic test_decode_and_points();
    send_request(CMD_TICK,   3'd0, 4'd0,  1'b0);  // first tick wraps to digit 0, blank
    send_request(CMD_WRITE,  3'd0, 4'd9,  1'b0);
    send_request(CMD_WRITE,  3'd1, 4'd0,  1'b0);
    send_request(CMD_WRITE,  3'd2, 4'd10, 1'b0);  // above nine shows blank
    send_request(CMD_WRITE,  3'd7, 4'd15, 1'b0);
    send_request(CMD_WRITE,  3'd3, 4'd8,  1'b0);
    send_request(CMD_TOGGLE, 3'd7, 4'd0,  1'b0);  // point on a blank digit
    send_request(CMD_TOGGLE, 3'd1, 4'd0,  1'b0);
    send_request(CMD_WRITE,  3'd1, 4'd5,  1'b0);  // overwrite drops the point
    send_request(CMD_NOP,    3'd7, 4'd15, 1'b1);  // must not clear anything
    repeat (8) send_request(CMD_TICK, 3'd0, 4'd0, 1'b0);
  endtask

  // a short display: clear with an out-of-range write, ignored toggle
  task automatic test_short_display();
    apply_setting(4'd3, 3'd0, 3'd0, 16'd0, 4'b1111);
    send_request(CMD_WRITE,  3'd5, 4'd4, 1'b1);  // clears store, digit itself dropped
    send_request(CMD_TOGGLE, 3'd6, 4'd0, 1'b0);  // beyond count, ignored
    send_request(CMD_WRITE,  3'd2, 4'd7, 1'b0);
    repeat (4) send_request(CMD_TICK, 3'd0, 4'd0, 1'b0);
  endtask

  // register extremes: clamped counts, widest period, empty blink range
  task automatic test_register_extremes();
    set_pacing(3);
    apply_setting(4'd0,  3'd0, 3'd7, 16'd2,     4'b1111);
    repeat (50) random_request();
    apply_setting(4'd15, 3'd7, 3'd7, 16'hFFFF,  4'b1111);
    repeat (50) random_request();
    apply_setting(4'd8,  3'd6, 3'd1, 16'd3,     4'b1111);
    repeat (60) random_request();
    apply_setting(4'd2,  3'd0, 3'd7, 16'd1,     4'b1111);
    repeat (50) random_request();
    apply_setting(4'd3,  3'd0, 3'd2, 16'd3,     4'b1111);
    repeat (60) random_request();
    // digit count alone: blink phase keeps running, scan position stays put
    apply_setting(4'd6,  3'd0, 3'd0, 16'd0,     4'b0001);
    repeat (60) random_request();
  endtask

  // long random traffic under each pacing, fresh settings per phase
  task automatic test_random_traffic();
    logic [3:0]  nd;
    logic [15:0] len;
    for (int phase = 0; phase < 8; phase++) begin
      nd  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
      len = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      if (phase == 7) len = 16'hFFFF;
      apply_setting(nd, 3'($urandom_range(7)), 3'($urandom_range(7)), len, 4'b1111);
      set_pacing(phase % 4);
      repeat (190) random_request();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    digits_reg    = NUM_DIGITS_RST;
    blink_lo_reg  = '0;
    blink_hi_reg  = '0;
    blink_len_reg = '0;
    foreach (glyph_store[i]) glyph_store[i] = '0;
    scan_pos      = shown_digits() - 1;
    blink_phase   = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_decode_and_points();
    test_short_display();
    test_register_extremes();
    test_random_traffic();

    wait_quiet();
    repeat (10) @(posedge clk);

    $display("covered %0d requests and %0d scan results across %0d register settings",
             requests_sent, scans_seen, settings_used);
    $display("pacing: free running, idle sender, stalled receiver, light idling on both");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== multiplexed_seven_segment_scanner.f =====
+incdir+rtl/core
rtl/core/msss_pkg.sv
rtl/core/msss_ram.sv
rtl/core/multiplexed_seven_segment_scanner.sv
test/tb_multiplexed_seven_segment_scanner.sv
